// ----- src/ssr_pkg.sv -----
// Shared types and constants for the servo slew ramp pulse width unit.
package ssr_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int PULSE_BITS_DEF = 16;

   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_PULSE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_PULSE     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_ANGLE    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_PER_TICK = 2'd3;

   localparam int MIN_PULSE_RESET     = 400;
   localparam int MAX_PULSE_RESET     = 1075;
   localparam int FULL_ANGLE_RESET    = 13500;
   localparam int STEP_PER_TICK_RESET = 65535;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } ssr_state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_step;
      logic out_load;
   } ssr_cmd_type;

   typedef struct packed {
      logic out_free;
   } ssr_status_type;

endpackage

// ----- src/ssr_if.sv -----
// Handshake channel interfaces for the request and response items.
interface ssr_req_if #(
   parameter int ANGLE_BITS = ssr_pkg::ANGLE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [ANGLE_BITS-1:0] target_angle;

   modport source (output valid, output target_angle, input ready);
   modport sink   (input valid, input target_angle, output ready);
endinterface

interface ssr_rsp_if #(
   parameter int ANGLE_BITS = ssr_pkg::ANGLE_BITS_DEF,
   parameter int PULSE_BITS = ssr_pkg::PULSE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [PULSE_BITS-1:0] pulse_ticks;
   logic [ANGLE_BITS-1:0] present_angle;
   logic                  at_target;

   modport source (output valid, output pulse_ticks, output present_angle,
                   output at_target, input ready);
   modport sink   (input valid, input pulse_ticks, input present_angle,
                   input at_target, output ready);
endinterface

// ----- src/ssr_ctrl.sv -----
// Controller state machine that sequences slew, multiply, divide and output.
module ssr_ctrl #(
   parameter int ANGLE_BITS = ssr_pkg::ANGLE_BITS_DEF,
   parameter int PULSE_BITS = ssr_pkg::PULSE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ssr_pkg::ssr_status_type status,
   output ssr_pkg::ssr_cmd_type    cmd
);
   import ssr_pkg::*;

   localparam int DIV_STEPS = ANGLE_BITS + PULSE_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   ssr_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             div_last;

   assign div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cnt_in       = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            cnt_in  = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
         end
         ST_OUT: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- src/ssr_datapath.sv -----
// Datapath: settings, ramp angle, slew step, multiplier, serial divider, output.
module ssr_datapath #(
   parameter int ANGLE_BITS = ssr_pkg::ANGLE_BITS_DEF,
   parameter int PULSE_BITS = ssr_pkg::PULSE_BITS_DEF,
   parameter int CSR_W      = (ANGLE_BITS > PULSE_BITS) ? ANGLE_BITS : PULSE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ssr_pkg::ssr_cmd_type                cmd,
   output ssr_pkg::ssr_status_type             status,
   input  logic                                csr_wr_en,
   input  logic [ssr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_W-1:0]                    csr_data,
   input  logic [ANGLE_BITS-1:0]               target_angle,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [PULSE_BITS-1:0]               pulse_ticks,
   output logic [ANGLE_BITS-1:0]               present_angle,
   output logic                                at_target
);
   import ssr_pkg::*;

   localparam int W = ANGLE_BITS + PULSE_BITS;

   logic [PULSE_BITS-1:0] min_pulse_ff, max_pulse_ff;
   logic [ANGLE_BITS-1:0] full_angle_ff, step_ff;
   logic [ANGLE_BITS-1:0] ramp_ff, ramp_in;
   logic [ANGLE_BITS-1:0] target_ff;
   logic [W-1:0]          quot_ff, quot_in;
   logic [ANGLE_BITS-1:0] rem_ff, rem_in;
   logic                  out_valid_ff;
   logic [PULSE_BITS-1:0] pulse_ff, pulse_in;
   logic [ANGLE_BITS-1:0] angle_ff;
   logic                  at_ff;

   logic [ANGLE_BITS:0]   up_sum;
   logic [ANGLE_BITS-1:0] down_diff;
   logic [PULSE_BITS-1:0] span;
   logic [W-1:0]          product;
   logic [ANGLE_BITS:0]   rem_shift;
   logic                  rem_ge;
   logic                  inverted;

   // Settings registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff  <= PULSE_BITS'(MIN_PULSE_RESET);
         max_pulse_ff  <= PULSE_BITS'(MAX_PULSE_RESET);
         full_angle_ff <= ANGLE_BITS'(FULL_ANGLE_RESET);
         step_ff       <= ANGLE_BITS'(STEP_PER_TICK_RESET);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_PULSE:     min_pulse_ff  <= csr_data[PULSE_BITS-1:0];
            CSR_MAX_PULSE:     max_pulse_ff  <= csr_data[PULSE_BITS-1:0];
            CSR_FULL_ANGLE:    full_angle_ff <= csr_data[ANGLE_BITS-1:0];
            CSR_STEP_PER_TICK: step_ff       <= csr_data[ANGLE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Slew step toward the target, landing exactly on it when the step reaches it.
   always_comb begin
      up_sum    = {1'b0, ramp_ff} + {1'b0, step_ff};
      down_diff = ramp_ff - target_angle;
      if (ramp_ff < target_angle) begin
         ramp_in = (up_sum > {1'b0, target_angle}) ? target_angle
                                                   : up_sum[ANGLE_BITS-1:0];
      end else if (ramp_ff > target_angle) begin
         ramp_in = (step_ff >= down_diff) ? target_angle : (ramp_ff - step_ff);
      end else begin
         ramp_in = ramp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff <= '0;
      end else if (cmd.load) begin
         ramp_ff <= ramp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         target_ff <= target_angle;
      end
   end

   // Product of span and angle, then one quotient bit per cycle.
   assign inverted  = (max_pulse_ff < min_pulse_ff);
   assign span      = max_pulse_ff - min_pulse_ff;
   assign product   = {{ANGLE_BITS{1'b0}}, span} * {{PULSE_BITS{1'b0}}, ramp_ff};
   assign rem_shift = {rem_ff, quot_ff[W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, full_angle_ff});

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (cmd.mul) begin
         quot_in = product;
         rem_in  = '0;
      end else if (cmd.div_step) begin
         quot_in = {quot_ff[W-2:0], rem_ge};
         rem_in  = rem_ge ? ANGLE_BITS'(rem_shift - {1'b0, full_angle_ff})
                          : rem_shift[ANGLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   // Pulse selection with clamping to the configured range.
   always_comb begin
      if (inverted) begin
         pulse_in = min_pulse_ff;
      end else if (full_angle_ff == '0) begin
         pulse_in = (ramp_ff != '0) ? max_pulse_ff : min_pulse_ff;
      end else if (quot_ff > {{ANGLE_BITS{1'b0}}, span}) begin
         pulse_in = max_pulse_ff;
      end else begin
         pulse_in = min_pulse_ff + quot_ff[PULSE_BITS-1:0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pulse_ff <= pulse_in;
         angle_ff <= ramp_ff;
         at_ff    <= (ramp_ff == target_ff);
      end
   end

   assign status.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign pulse_ticks     = pulse_ff;
   assign present_angle   = angle_ff;
   assign at_target       = at_ff;

endmodule

// ----- src/servo_slew_ramp_pulse_width_unit.sv -----
// Top level of the slew-rate-limited servo pulse width unit.
//
// Usage: each item on the req channel is one servo update tick that carries the
// commanded angle in hundredths of a degree. The ramped angle moves toward it by
// at most step_per_tick, then is mapped linearly from min_pulse at zero angle to
// max_pulse at full_angle, clamped to that range. Each request item yields exactly
// one rsp item with the pulse width in timer ticks, the ramped angle and a flag
// that is set when the ramped angle equals the target.
// Sequence: the slew step is taken at acceptance, the product span * angle is
// then registered, and a restoring divider produces ANGLE_BITS + PULSE_BITS
// quotient bits, one per cycle. The result is then loaded into the output
// register, and the block is ready for the next item in the cycle after that.
// A finished result waits in the output register while the next item is worked
// on; if the receiver still stalls when that item is done, the block holds it.
// Reset (synchronous, active high) sets the ramped angle to zero and the settings
// to their defaults. The user must write settings through csr_* only while idle;
// the block itself does not enforce this.
module servo_slew_ramp_pulse_width_unit #(
   parameter int ANGLE_BITS = ssr_pkg::ANGLE_BITS_DEF,
   parameter int PULSE_BITS = ssr_pkg::PULSE_BITS_DEF,
   parameter int CSR_W      = (ANGLE_BITS > PULSE_BITS) ? ANGLE_BITS : PULSE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   ssr_req_if.sink                            req,
   ssr_rsp_if.source                          rsp,
   input  logic                               csr_wr_en,
   input  logic [ssr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_W-1:0]                   csr_data
);
   import ssr_pkg::*;

   ssr_cmd_type    cmd;
   ssr_status_type status;

   // The controller owns sequencing, its state and step counter; the datapath owns every other stored value.
   ssr_ctrl #(
      .ANGLE_BITS (ANGLE_BITS),
      .PULSE_BITS (PULSE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssr_datapath #(
      .ANGLE_BITS (ANGLE_BITS),
      .PULSE_BITS (PULSE_BITS),
      .CSR_W      (CSR_W)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .target_angle  (req.target_angle),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .pulse_ticks   (rsp.pulse_ticks),
      .present_angle (rsp.present_angle),
      .at_target     (rsp.at_target)
   );

`ifndef SYNTHESIS
   // Only one item is in the datapath at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted while an item is still in flight");

   // A loaded result is presented on the next cycle.
   a_out_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp.valid)
      else $error("loaded result not presented");

   // Divider steps, multiply and output loads never run while the block is ready for a new item.
   a_no_div_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !cmd.div_step && !cmd.mul && !cmd.out_load)
      else $error("datapath command issued while idle");

   // The ramp state only changes on an accepted request.
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req.valid && req.ready))
      else $error("ramp update without an accepted request");
`endif

endmodule
